>>> design/fts_pkg.sv
// Shared types, constants and tables for the Unix seconds to FAT timestamp pipeline.
`default_nettype none

package fts_pkg;

  // Register stages from input to output register, output register included.
  localparam int unsigned NUM_STAGES = 12;

  localparam int unsigned SECS_W = 36;
  localparam int unsigned FAT_W  = 32;

  // Seconds to days: the low 7 bits of 86400 are split off, the rest is 675.
  localparam logic [9:0]  DAY_DIV   = 10'd675;
  localparam int unsigned DAY_SHIFT = 39;
  localparam logic [29:0] DAY_MUL   =
    30'(((64'd1 << DAY_SHIFT) + 64'(DAY_DIV) - 64'd1) / 64'(DAY_DIV));

  localparam logic [20:0] EPOCH_SHIFT = 21'd719468;

  localparam logic [17:0] ERA_DIV   = 18'd146097;
  localparam int unsigned ERA_SHIFT = 39;
  localparam logic [21:0] ERA_MUL   =
    22'(((64'd1 << ERA_SHIFT) + 64'(ERA_DIV) - 64'd1) / 64'(ERA_DIV));

  // Seconds to minutes and minutes to hours divide by 60 as a shift by 2 and a divide by 15.
  localparam logic [3:0]  TOD_DIV   = 4'd15;
  localparam int unsigned TOD_SHIFT = 19;
  localparam logic [15:0] TOD_MUL   =
    16'(((64'd1 << TOD_SHIFT) + 64'(TOD_DIV) - 64'd1) / 64'(TOD_DIV));
  localparam logic [5:0]  SECS_PER_MIN = 6'd60;

  // doe / 1460 is (doe / 4) / 365.
  localparam logic [8:0]  YEAR_DAYS  = 9'd365;
  localparam int unsigned Q4Y_SHIFT  = 25;
  localparam logic [16:0] Q4Y_MUL    =
    17'(((64'd1 << Q4Y_SHIFT) + 64'(YEAR_DAYS) - 64'd1) / 64'(YEAR_DAYS));

  // doe / 36524 is (doe / 4) / 9131.
  localparam logic [13:0] CENT_DIV   = 14'd9131;
  localparam int unsigned CENT_SHIFT = 30;
  localparam logic [16:0] CENT_MUL   =
    17'(((64'd1 << CENT_SHIFT) + 64'(CENT_DIV) - 64'd1) / 64'(CENT_DIV));

  localparam logic [17:0] DOE_LAST = 18'd146096;

  localparam int unsigned YOE_SHIFT = 27;
  localparam logic [18:0] YOE_MUL   =
    19'(((64'd1 << YOE_SHIFT) + 64'(YEAR_DAYS) - 64'd1) / 64'(YEAR_DAYS));

  localparam logic [6:0]  Y100_DIV   = 7'd100;
  localparam int unsigned Y100_SHIFT = 16;
  localparam logic [9:0]  Y100_MUL   =
    10'(((64'd1 << Y100_SHIFT) + 64'(Y100_DIV) - 64'd1) / 64'(Y100_DIV));

  localparam logic [7:0]  MP_DIV   = 8'd153;
  localparam int unsigned MP_SHIFT = 19;
  localparam logic [11:0] MP_MUL   =
    12'(((64'd1 << MP_SHIFT) + 64'(MP_DIV) - 64'd1) / 64'(MP_DIV));

  localparam logic [8:0]  ERA_YEARS     = 9'd400;
  localparam logic [12:0] FAT_YEAR_BASE = 13'd1980;
  localparam logic [12:0] FAT_YEAR_TOP  = 13'd2107;

  typedef struct packed {
    logic [12:0] year;
    logic [3:0]  month;
    logic [4:0]  mday;
  } date_t;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [4:0] sec2;
  } tod_t;

  // First day of each month in a year that starts on March 1.
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] d;
    unique case (mp)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd61;
      4'd3:    d = 9'd92;
      4'd4:    d = 9'd122;
      4'd5:    d = 9'd153;
      4'd6:    d = 9'd184;
      4'd7:    d = 9'd214;
      4'd8:    d = 9'd245;
      4'd9:    d = 9'd275;
      4'd10:   d = 9'd306;
      4'd11:   d = 9'd337;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

>>> design/unix_seconds_to_fat_timestamp_core.sv
// Top level of the Unix seconds to FAT date-time converter.
`default_nettype none

// Converts a 36-bit count of seconds since 1970-01-01 UTC into the packed
// 32-bit FAT date-time word. The block is a 12-stage pipeline with no state
// between requests: it takes one request per clock cycle unless a stalled
// output has backed it up, and delivers results once out_ready is high. Every
// division by a constant is an exact reciprocal multiply, some followed by a
// registered remainder step; the widest multiplier, 29 by 30 bits, sits in
// the first stage. Stages hand data forward whenever the next one is empty or
// moving, so internal bubbles close up while a result waits at the output.
// Years before 1980 give January 1, 1980 at midnight; years after 2107 clamp
// only the year field.
module unix_seconds_to_fat_timestamp_core (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [fts_pkg::SECS_W-1:0]     in_unix_seconds,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [fts_pkg::FAT_W-1:0]           out_fat_timestamp
);

  logic [fts_pkg::NUM_STAGES-1:0] en;
  logic [16:0]                    sod;
  logic [20:0]                    shifted;
  fts_pkg::tod_t                  tod;
  fts_pkg::date_t                 date;

  fts_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .en        (en)
  );

  fts_day_split u_days (
    .clk     (clk),
    .en      (en[1:0]),
    .in_sec  (in_unix_seconds),
    .sod     (sod),
    .shifted (shifted)
  );

  fts_tod u_tod (
    .clk (clk),
    .en  (en[10:2]),
    .sod (sod),
    .tod (tod)
  );

  fts_civil u_civil (
    .clk     (clk),
    .en      (en[10:2]),
    .shifted (shifted),
    .date    (date)
  );

  fts_pack u_pack (
    .clk  (clk),
    .en   (en[11]),
    .date (date),
    .tod  (tod),
    .fat  (out_fat_timestamp)
  );

endmodule

`default_nettype wire

>>> design/fts_pipe_ctrl.sv
// Valid bits and per-stage load enables of the conversion pipeline.
`default_nettype none

module fts_pipe_ctrl (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [fts_pkg::NUM_STAGES-1:0]       en
);

  localparam int unsigned N = fts_pkg::NUM_STAGES;

  logic [N-1:0] v_r;
  logic [N-1:0] v_nxt;

  // A stage loads when it is empty or when the stage after it loads too.
  always_comb begin
    en[N-1] = !v_r[N-1] || out_ready;
    for (int i = N - 2; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
    v_nxt = ({v_r[N-2:0], in_valid} & en) | (v_r & ~en);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[N-1];

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> v_r[0])
    else $error("accepted request did not enter the first stage");

  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    ((&v_r) && !out_ready) |-> !in_ready)
    else $error("full pipeline accepted a request while stalled");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[N-2] && !en[N-1]) |=> (v_r[N-2] && v_r[N-1]))
    else $error("stalled request was lost");

  a_out_from_prev: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(v_r[N-1]) |-> $past(v_r[N-2]))
    else $error("result appeared without a request behind it");

endmodule

`default_nettype wire

>>> design/fts_day_split.sv
// Splits Unix seconds into whole days and the second of the day (stages 0 and 1).
`default_nettype none

module fts_day_split (
  input  wire logic                           clk,
  input  wire logic [1:0]                     en,
  input  wire logic [fts_pkg::SECS_W-1:0]     in_sec,
  output logic [16:0]                         sod,
  output logic [20:0]                         shifted
);

  logic [58:0] day_prod;
  logic [28:0] x_r;
  logic [6:0]  lo_r;
  logic [19:0] q_r;
  logic [28:0] rem;
  logic [16:0] sod_r;
  logic [20:0] shifted_r;

  // Exact reciprocal: (secs / 128) / 675 is the day count.
  assign day_prod = 59'(in_sec[35:7]) * 59'(fts_pkg::DAY_MUL);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      x_r  <= in_sec[35:7];
      lo_r <= in_sec[6:0];
      q_r  <= day_prod[fts_pkg::DAY_SHIFT+19:fts_pkg::DAY_SHIFT];
    end
  end

  assign rem = x_r - 29'(30'(q_r) * 30'(fts_pkg::DAY_DIV));

  always_ff @(posedge clk) begin
    if (en[1]) begin
      sod_r     <= {rem[9:0], lo_r};
      shifted_r <= 21'(q_r) + fts_pkg::EPOCH_SHIFT;
    end
  end

  assign sod     = sod_r;
  assign shifted = shifted_r;

endmodule

`default_nettype wire

>>> design/fts_tod.sv
// Hour, minute and two-second count from the second of the day (stages 2 to 10).
`default_nettype none

module fts_tod (
  input  wire logic                           clk,
  input  wire logic [10:2]                    en,
  input  wire logic [16:0]                    sod,
  output fts_pkg::tod_t                       tod
);

  logic [30:0]   mt_prod;
  logic [10:0]   mt_r;
  logic [16:0]   sod_r;
  logic [30:0]   hr_prod;
  logic [16:0]   sec_full;
  logic [4:0]    hour_r;
  logic [4:0]    sec2_r;
  logic [10:0]   mt3_r;
  logic [10:0]   min_full;
  fts_pkg::tod_t tod_r [4:10];

  // Minutes of the day: (sod / 4) / 15.
  assign mt_prod = 31'(sod[16:2]) * 31'(fts_pkg::TOD_MUL);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      mt_r  <= mt_prod[fts_pkg::TOD_SHIFT+10:fts_pkg::TOD_SHIFT];
      sod_r <= sod;
    end
  end

  assign hr_prod  = 31'(mt_r[10:2]) * 31'(fts_pkg::TOD_MUL);
  assign sec_full = sod_r - 17'(17'(mt_r) * 17'(fts_pkg::SECS_PER_MIN));

  always_ff @(posedge clk) begin
    if (en[3]) begin
      hour_r <= hr_prod[fts_pkg::TOD_SHIFT+4:fts_pkg::TOD_SHIFT];
      sec2_r <= sec_full[5:1];
      mt3_r  <= mt_r;
    end
  end

  assign min_full = mt3_r - 11'(11'(hour_r) * 11'(fts_pkg::SECS_PER_MIN));

  always_ff @(posedge clk) begin
    if (en[4]) begin
      tod_r[4].hour   <= hour_r;
      tod_r[4].minute <= min_full[5:0];
      tod_r[4].sec2   <= sec2_r;
    end
  end

  // The time fields wait here for the date path to finish.
  for (genvar s = 5; s <= 10; s++) begin : g_dly
    always_ff @(posedge clk) begin
      if (en[s]) begin
        tod_r[s] <= tod_r[s-1];
      end
    end
  end

  assign tod = tod_r[10];

endmodule

`default_nettype wire

>>> design/fts_civil.sv
// Civil date from the shifted day count (stages 2 to 10).
`default_nettype none

module fts_civil (
  input  wire logic                           clk,
  input  wire logic [10:2]                    en,
  input  wire logic [20:0]                    shifted,
  output fts_pkg::date_t                      date
);

  logic [42:0]    era_prod;
  logic [3:0]     era2_r;
  logic [20:0]    sh2_r;
  logic [20:0]    doe_full;
  logic [17:0]    doe3_r;
  logic [3:0]     era3_r;
  logic [32:0]    q4y_prod;
  logic [32:0]    cent_prod;
  logic [6:0]     a4_r;
  logic [2:0]     b4_r;
  logic           c4_r;
  logic [17:0]    doe4_r;
  logic [3:0]     era4_r;
  logic [17:0]    v5_r;
  logic [17:0]    doe5_r;
  logic [3:0]     era5_r;
  logic [36:0]    yoe_prod;
  logic [8:0]     yoe6_r;
  logic [17:0]    doe6_r;
  logic [3:0]     era6_r;
  logic [18:0]    y100_prod;
  logic [17:0]    y365_r;
  logic [1:0]     y100_r;
  logic [8:0]     yoe7_r;
  logic [17:0]    doe7_r;
  logic [3:0]     era7_r;
  logic [17:0]    doy_full;
  logic [8:0]     doy8_r;
  logic [12:0]    yr8_r;
  logic [10:0]    mp_num;
  logic [22:0]    mp_prod;
  logic [3:0]     mp9_r;
  logic [8:0]     doy9_r;
  logic [12:0]    yr9_r;
  logic [3:0]     month;
  logic [8:0]     mday_full;
  fts_pkg::date_t date_r;

  assign era_prod = 43'(shifted) * 43'(fts_pkg::ERA_MUL);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      era2_r <= era_prod[fts_pkg::ERA_SHIFT+3:fts_pkg::ERA_SHIFT];
      sh2_r  <= shifted;
    end
  end

  assign doe_full = sh2_r - 21'(21'(era2_r) * 21'(fts_pkg::ERA_DIV));

  always_ff @(posedge clk) begin
    if (en[3]) begin
      doe3_r <= doe_full[17:0];
      era3_r <= era2_r;
    end
  end

  assign q4y_prod  = 33'(doe3_r[17:2]) * 33'(fts_pkg::Q4Y_MUL);
  assign cent_prod = 33'(doe3_r[17:2]) * 33'(fts_pkg::CENT_MUL);

  always_ff @(posedge clk) begin
    if (en[4]) begin
      a4_r   <= q4y_prod[fts_pkg::Q4Y_SHIFT+6:fts_pkg::Q4Y_SHIFT];
      b4_r   <= cent_prod[fts_pkg::CENT_SHIFT+2:fts_pkg::CENT_SHIFT];
      c4_r   <= (doe3_r == fts_pkg::DOE_LAST);
      doe4_r <= doe3_r;
      era4_r <= era3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      v5_r   <= doe4_r - 18'(a4_r) + 18'(b4_r) - 18'(c4_r);
      doe5_r <= doe4_r;
      era5_r <= era4_r;
    end
  end

  assign yoe_prod = 37'(v5_r) * 37'(fts_pkg::YOE_MUL);

  always_ff @(posedge clk) begin
    if (en[6]) begin
      yoe6_r <= yoe_prod[fts_pkg::YOE_SHIFT+8:fts_pkg::YOE_SHIFT];
      doe6_r <= doe5_r;
      era6_r <= era5_r;
    end
  end

  assign y100_prod = 19'(yoe6_r) * 19'(fts_pkg::Y100_MUL);

  always_ff @(posedge clk) begin
    if (en[7]) begin
      y365_r <= 18'(yoe6_r) * 18'(fts_pkg::YEAR_DAYS);
      y100_r <= y100_prod[fts_pkg::Y100_SHIFT+1:fts_pkg::Y100_SHIFT];
      yoe7_r <= yoe6_r;
      doe7_r <= doe6_r;
      era7_r <= era6_r;
    end
  end

  // Day of the March-based year: leap days are added every fourth year, less centuries.
  assign doy_full = doe7_r - (y365_r + 18'(yoe7_r[8:2]) - 18'(y100_r));

  always_ff @(posedge clk) begin
    if (en[8]) begin
      doy8_r <= doy_full[8:0];
      yr8_r  <= 13'(yoe7_r) + 13'(13'(era7_r) * 13'(fts_pkg::ERA_YEARS));
    end
  end

  assign mp_num  = {doy8_r, 2'b00} + 11'(doy8_r) + 11'd2;
  assign mp_prod = 23'(mp_num) * 23'(fts_pkg::MP_MUL);

  always_ff @(posedge clk) begin
    if (en[9]) begin
      mp9_r  <= mp_prod[fts_pkg::MP_SHIFT+3:fts_pkg::MP_SHIFT];
      doy9_r <= doy8_r;
      yr9_r  <= yr8_r;
    end
  end

  // Months March to December come first; January and February belong to the next year.
  assign month     = (mp9_r < 4'd10) ? (mp9_r + 4'd3) : (mp9_r - 4'd9);
  assign mday_full = doy9_r - fts_pkg::month_start(mp9_r) + 9'd1;

  always_ff @(posedge clk) begin
    if (en[10]) begin
      date_r.month <= month;
      date_r.mday  <= mday_full[4:0];
      date_r.year  <= yr9_r + 13'(month <= 4'd2);
    end
  end

  assign date = date_r;

endmodule

`default_nettype wire

>>> design/fts_pack.sv
// Year range handling and packing of the FAT date-time word (stage 11).
`default_nettype none

module fts_pack (
  input  wire logic                           clk,
  input  wire logic                           en,
  input  wire fts_pkg::date_t                 date,
  input  wire fts_pkg::tod_t                  tod,
  output logic [fts_pkg::FAT_W-1:0]           fat
);

  logic [12:0]               yoff;
  logic [6:0]                yfield;
  logic [fts_pkg::FAT_W-1:0] word;
  logic [fts_pkg::FAT_W-1:0] fat_r;

  assign yoff = date.year - fts_pkg::FAT_YEAR_BASE;

  always_comb begin
    yfield = (date.year > fts_pkg::FAT_YEAR_TOP) ? 7'h7f : yoff[6:0];
    // Dates before 1980 collapse to January 1, 1980 at midnight.
    if (date.year < fts_pkg::FAT_YEAR_BASE) begin
      word = {7'd0, 4'd1, 5'd1, 16'd0};
    end else begin
      word = {yfield, date.month, date.mday, tod.hour, tod.minute, tod.sec2};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fat_r <= word;
    end
  end

  assign fat = fat_r;

endmodule

`default_nettype wire

>>> test/fat_word_checker.sv
// Checker that predicts and compares the FAT date-time words leaving the converter.
`timescale 1ns / 100ps

module fat_word_checker (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  input  wire logic                       in_ready,
  input  wire logic [fts_pkg::SECS_W-1:0] in_unix_seconds,
  input  wire logic                       out_valid,
  input  wire logic                       out_ready,
  input  wire logic [fts_pkg::FAT_W-1:0]  out_fat_timestamp,
  output int unsigned                     fail_count,
  output int unsigned                     pending,
  output int unsigned                     checked_count,
  output int unsigned                     pre_1980_count,
  output int unsigned                     post_2107_count
);

  localparam logic [63:0] SECS_PER_DAY  = 64'd86400;
  localparam logic [31:0] SECS_PER_HOUR = 32'd3600;
  localparam logic [31:0] SECS_PER_MIN  = 32'd60;
  localparam logic [63:0] MARCH_EPOCH   = 64'd719468;
  localparam logic [63:0] ERA_DAYS      = 64'd146097;
  localparam logic [31:0] LAST_ERA_DAY  = 32'd146096;
  localparam logic [31:0] FOUR_YEARS    = 32'd1460;
  localparam logic [31:0] CENTURY_DAYS  = 32'd36524;
  localparam logic [31:0] DAYS_IN_YEAR  = 32'd365;
  localparam logic [31:0] MONTH_SPAN    = 32'd153;
  localparam logic [63:0] YEAR_FLOOR    = 64'd1980;
  localparam logic [63:0] YEAR_CEIL     = 64'd2107;

  typedef struct {
    logic [fts_pkg::SECS_W-1:0] seconds;
    logic [fts_pkg::FAT_W-1:0]  word;
  } fat_expect_t;

  fat_expect_t expected_words[$];

  // Civil date from a day count, with day zero on March 1 of year 0 so that
  // the leap day falls at the end of each shifted year.
  function automatic logic [31:0] fat_word_of(input logic [fts_pkg::SECS_W-1:0] secs,
                                              output bit too_early, output bit too_late);
    logic [63:0] days, shifted, era, year;
    logic [31:0] sod, hour, minute, second, doe, yoe, doy, mp, mday, month;
    days    = 64'(secs) / SECS_PER_DAY;
    sod     = 32'(64'(secs) % SECS_PER_DAY);
    hour    = sod / SECS_PER_HOUR;
    minute  = (sod / SECS_PER_MIN) % SECS_PER_MIN;
    second  = sod % SECS_PER_MIN;
    shifted = days + MARCH_EPOCH;
    era     = shifted / ERA_DAYS;
    doe     = 32'(shifted - era * ERA_DAYS);
    yoe     = (doe - doe / FOUR_YEARS + doe / CENTURY_DAYS - doe / LAST_ERA_DAY) / DAYS_IN_YEAR;
    year    = 64'(yoe) + era * 64'd400;
    doy     = doe - (DAYS_IN_YEAR * yoe + yoe / 32'd4 - yoe / 32'd100);
    mp      = (32'd5 * doy + 32'd2) / MONTH_SPAN;
    mday    = doy - (MONTH_SPAN * mp + 32'd2) / 32'd5 + 32'd1;
    month   = (mp < 32'd10) ? mp + 32'd3 : mp - 32'd9;
    if (month <= 32'd2) year = year + 64'd1;
    too_early = (year < YEAR_FLOOR);
    too_late  = (year > YEAR_CEIL);
    if (too_early) begin
      year   = YEAR_FLOOR;
      month  = 32'd1;
      mday   = 32'd1;
      hour   = 32'd0;
      minute = 32'd0;
      second = 32'd0;
    end
    if (too_late) year = YEAR_CEIL;
    return {7'(year - YEAR_FLOOR), month[3:0], mday[4:0], hour[4:0], minute[5:0],
            5'(second / 32'd2)};
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] ERROR %s", $realtime, what);
    fail_count++;
  endtask

  initial begin
    fail_count      = 0;
    pending         = 0;
    checked_count   = 0;
    pre_1980_count  = 0;
    post_2107_count = 0;
  end

  always @(posedge clk) begin
    fat_expect_t exp_item;
    bit          early, late;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        exp_item.seconds = in_unix_seconds;
        exp_item.word    = fat_word_of(in_unix_seconds, early, late);
        if (early) pre_1980_count++;
        if (late) post_2107_count++;
        expected_words.push_back(exp_item);
      end
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("unexpected result fat_timestamp=%08h", out_fat_timestamp));
        end else begin
          exp_item = expected_words.pop_front();
          checked_count++;
          if (out_fat_timestamp !== exp_item.word)
            report_mismatch($sformatf("seconds=%0d fat_timestamp got %08h expected %08h",
                                      exp_item.seconds, out_fat_timestamp, exp_item.word));
        end
      end
      pending = expected_words.size();
    end
  end

endmodule

>>> test/tb_unix_seconds_to_fat_timestamp_core.sv
// Testbench top: drives requests and ready into the converter and reports the verdict.
`timescale 1ns / 100ps

module tb_unix_seconds_to_fat_timestamp_core;

  localparam int unsigned RANDOM_REQUESTS = 800;
  localparam int unsigned QUIET_TAIL      = 120;
  localparam int unsigned HOLD_OFF_AFTER  = 100;
  localparam int unsigned HOLD_OFF_CYCLES = 80;
  localparam longint      RUN_LIMIT_NS    = 5_000_000;
  // First second of 1980 and first second of 2108.
  localparam logic [35:0] FAT_EPOCH_SECS  = 36'd315532800;
  localparam logic [35:0] FAT_END_SECS    = 36'd4354819200;
  localparam logic [31:0] FAT_SPAN_SECS   = 32'(FAT_END_SECS - FAT_EPOCH_SECS - 36'd1);

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [fts_pkg::SECS_W-1:0] in_unix_seconds = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [fts_pkg::FAT_W-1:0]  out_fat_timestamp;

  int unsigned fail_count, pending, checked_count, pre_1980_count, post_2107_count;
  int unsigned sent_count = 0;
  int unsigned total_requests = 0;
  int unsigned input_stall_cycles = 0;
  bit          quiet_tail = 1'b0;

  always #5 clk = ~clk;

  unix_seconds_to_fat_timestamp_core u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_unix_seconds   (in_unix_seconds),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_fat_timestamp (out_fat_timestamp)
  );

  fat_word_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_unix_seconds   (in_unix_seconds),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_fat_timestamp (out_fat_timestamp),
    .fail_count        (fail_count),
    .pending           (pending),
    .checked_count     (checked_count),
    .pre_1980_count    (pre_1980_count),
    .post_2107_count   (post_2107_count)
  );

  initial begin
    #(RUN_LIMIT_NS);
    $display("unix_seconds_to_fat_timestamp_core: mismatch");
    $finish;
  end

  always @(negedge clk) begin
    if (in_valid && !in_ready) input_stall_cycles++;
  end

  // Called at a rising edge; returns after the request is taken and any idle gap.
  task automatic send_request(input logic [fts_pkg::SECS_W-1:0] secs);
    int unsigned gap;
    in_valid        <= 1'b1;
    in_unix_seconds <= secs;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    sent_count++;
    quiet_tail = (total_requests != 0) && (sent_count + QUIET_TAIL >= total_requests);
    if (!quiet_tail && $urandom_range(4, 0) == 0) begin
      gap = $urandom_range(12, 1);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Output side: random stalls, one long hold-off to back the pipeline up.
  initial begin
    int unsigned burst;
    bit          held_off;
    held_off = 1'b0;
    do @(negedge clk); while (!rst_n);
    forever begin
      @(posedge clk);
      if (!held_off && sent_count >= HOLD_OFF_AFTER) begin
        held_off = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(posedge clk);
      end else if (!quiet_tail && $urandom_range(3, 0) == 0) begin
        burst = $urandom_range(12, 1);
        out_ready <= 1'b0;
        repeat (burst - 1) @(posedge clk);
      end else begin
        burst = $urandom_range(20, 1);
        out_ready <= 1'b1;
        repeat (burst - 1) @(posedge clk);
      end
    end
  end

  initial begin
    logic [fts_pkg::SECS_W-1:0] secs;
    int unsigned                day;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: field extremes, the edges of the FAT year range, leap days, bit patterns.
    send_request(36'd0);
    send_request(36'd1);
    send_request(36'd59);
    send_request(36'd3599);
    send_request(36'd86399);
    send_request(FAT_EPOCH_SECS - 36'd1);
    send_request(FAT_EPOCH_SECS);
    send_request(FAT_EPOCH_SECS + 36'd1);
    send_request(36'd951782399);
    send_request(36'd951782400);
    send_request(36'd951868800);
    send_request(36'd1735689599);
    send_request(36'd2147483647);
    send_request(36'd2147483648);
    send_request(36'd4107542399);
    send_request(36'd4107542400);
    send_request(36'd4294967295);
    send_request(36'd4294967296);
    send_request(FAT_END_SECS - 36'd1);
    send_request(FAT_END_SECS);
    send_request(36'h555555555);
    send_request(36'hAAAAAAAAA);
    send_request(36'h800000000);
    send_request(36'hFFFFFFFFF);

    total_requests = sent_count + RANDOM_REQUESTS;
    while (sent_count < total_requests) begin
      case ($urandom_range(9, 0))
        0, 1, 2, 3: secs = FAT_EPOCH_SECS + 36'($urandom_range(FAT_SPAN_SECS, 0));
        4, 5:       secs = 36'($urandom_range(32'(FAT_EPOCH_SECS - 36'd1), 0));
        6, 7:       secs = {4'($urandom_range(15, 0)), 32'($urandom())};
        default: begin
          // Around a midnight, where the date rolls over.
          day  = $urandom_range(60000, 1);
          secs = 36'(64'(day) * 64'd86400) + 36'($urandom_range(5, 0)) - 36'd3;
        end
      endcase
      send_request(secs);
    end
    in_valid <= 1'b0;

    do @(negedge clk); while (pending != 0);
    repeat (fts_pkg::NUM_STAGES + 4) @(posedge clk);
    @(negedge clk);
    $display("Converted %0d requests (%0d before 1980, %0d past 2107), %0d results checked.",
             sent_count, pre_1980_count, post_2107_count, checked_count);
    $display("Input side was held back for %0d cycles by output back-pressure.",
             input_stall_cycles);
    if (fail_count == 0 && pending == 0) begin
      $display("unix_seconds_to_fat_timestamp_core: match");
    end else begin
      $display("unix_seconds_to_fat_timestamp_core: mismatch");
    end
    $finish;
  end

endmodule
